FILE: rtl/core/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; clock and reset are passed in by the caller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define TKFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tkfs assertion failed");

// implication in the next cycle
`define TKFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tkfs assertion failed");

`endif

FILE: rtl/core/tkfs_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the top-k feature selector
// no dependencies
package tkfs_pkg;

    localparam int MAX_FEATURES = 32;
    localparam int COORD_BITS   = 12;
    localparam int SCORE_BITS   = 32;
    localparam int MAXC_BITS    = 6;

    // store index and fill count widths
    localparam int IDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int CNT_W = $clog2(MAX_FEATURES + 1);
    localparam int CMP_W = (CNT_W > MAXC_BITS) ? CNT_W : MAXC_BITS;

    localparam logic [SCORE_BITS-1:0] THRESHOLD_RESET = 32'd16777;
    localparam logic [MAXC_BITS-1:0]  MAX_COUNT_RESET = 6'd32;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_THRESHOLD = 2'd0;
    localparam t_cfg_idx CFG_MAX_COUNT = 2'd1;

    typedef struct packed {
        logic [SCORE_BITS-1:0] score;
        logic [COORD_BITS-1:0] pix_x;
        logic [COORD_BITS-1:0] pix_y;
        logic                  frame_end;
    } t_in_item;

    typedef struct packed {
        logic [SCORE_BITS-1:0] feat_score;
        logic [COORD_BITS-1:0] feat_x;
        logic [COORD_BITS-1:0] feat_y;
        logic                  is_last;
        logic                  none_found;
    } t_out_item;

    typedef struct packed {
        logic insert;    // an input request is taken this cycle
        logic load_out;  // move the store head into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic count_one;
    } t_dp_stat;

endpackage

FILE: rtl/core/tkfs_ctrl.sv
`timescale 1ns / 1ps
// controller: accept and emit sequencing, output valid
// depends on tkfs_pkg
module tkfs_ctrl import tkfs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_frame_end,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_accept;
    logic   w_load;
    logic   w_last;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_load      = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    assign w_last      = i_stat.count_zero || i_stat.count_one;

    always_comb begin
        o_cmd.insert   = w_accept;
        o_cmd.load_out = w_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && i_in_frame_end) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_load && w_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/tkfs_datapath.sv
`timescale 1ns / 1ps
// datapath: config registers, sorted compare-and-shift store, output register
// depends on tkfs_pkg
module tkfs_datapath import tkfs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_valid,
    input  t_cfg_idx  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  t_in_item  i_in_data,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output t_out_item o_out_data
);

    logic [SCORE_BITS-1:0] r_thr;
    logic [MAXC_BITS-1:0]  r_maxc;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;

    logic [SCORE_BITS-1:0] r_sc [MAX_FEATURES];
    logic [COORD_BITS-1:0] r_x  [MAX_FEATURES];
    logic [COORD_BITS-1:0] r_y  [MAX_FEATURES];
    logic [SCORE_BITS-1:0] n_sc [MAX_FEATURES];
    logic [COORD_BITS-1:0] n_x  [MAX_FEATURES];
    logic [COORD_BITS-1:0] n_y  [MAX_FEATURES];

    t_out_item r_out;

    logic [CNT_W-1:0]        w_cap;
    logic [CNT_W-1:0]        w_cnt_eff;
    logic [IDX_W-1:0]        w_cap_idx;
    logic [MAX_FEATURES-1:0] w_ge;
    logic [MAX_FEATURES-1:0] w_ge_prev;
    logic                    w_ins;

    always_comb begin
        // effective cap and store cut to it
        if (CMP_W'(r_maxc) < CMP_W'(MAX_FEATURES)) begin
            w_cap = CNT_W'(r_maxc);
        end else begin
            w_cap = CNT_W'(MAX_FEATURES);
        end
        w_cnt_eff = (r_count > w_cap) ? w_cap : r_count;
        w_cap_idx = IDX_W'(w_cap - CNT_W'(1));

        // per-cell compare: entry stays ahead of the new one
        for (int i = 0; i < MAX_FEATURES; i++) begin
            w_ge[i] = (CNT_W'(i) < w_cnt_eff) && (r_sc[i] >= i_in_data.score);
        end
        w_ge_prev[0] = 1'b1;
        for (int i = 1; i < MAX_FEATURES; i++) begin
            w_ge_prev[i] = w_ge[i-1];
        end

        w_ins = i_cmd.insert && (i_in_data.score > r_thr) && (w_cap != '0)
                && !w_ge[w_cap_idx];

        n_count = r_count;
        for (int i = 0; i < MAX_FEATURES; i++) begin
            n_sc[i] = r_sc[i];
            n_x[i]  = r_x[i];
            n_y[i]  = r_y[i];
        end

        if (i_cmd.insert) begin
            n_count = w_cnt_eff;
            if (w_ins) begin
                if (w_cnt_eff < w_cap) begin
                    n_count = w_cnt_eff + CNT_W'(1);
                end
                if (!w_ge[0]) begin
                    n_sc[0] = i_in_data.score;
                    n_x[0]  = i_in_data.pix_x;
                    n_y[0]  = i_in_data.pix_y;
                end
                for (int i = 1; i < MAX_FEATURES; i++) begin
                    if (!w_ge[i]) begin
                        if (w_ge_prev[i]) begin
                            n_sc[i] = i_in_data.score;
                            n_x[i]  = i_in_data.pix_x;
                            n_y[i]  = i_in_data.pix_y;
                        end else begin
                            n_sc[i] = r_sc[i-1];
                            n_x[i]  = r_x[i-1];
                            n_y[i]  = r_y[i-1];
                        end
                    end
                end
            end
        end else if (i_cmd.load_out) begin
            // pop the head, the chain moves up by one
            for (int i = 0; i < MAX_FEATURES - 1; i++) begin
                n_sc[i] = r_sc[i+1];
                n_x[i]  = r_x[i+1];
                n_y[i]  = r_y[i+1];
            end
            if (r_count != '0) begin
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THRESHOLD_RESET;
            r_maxc  <= MAX_COUNT_RESET;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_THRESHOLD: r_thr  <= i_cfg_data;
                    CFG_MAX_COUNT: r_maxc <= i_cfg_data[MAXC_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_FEATURES; i++) begin
            r_sc[i] <= n_sc[i];
            r_x[i]  <= n_x[i];
            r_y[i]  <= n_y[i];
        end
        if (i_cmd.load_out) begin
            if (r_count == '0) begin
                r_out.feat_score <= '0;
                r_out.feat_x     <= '0;
                r_out.feat_y     <= '0;
                r_out.none_found <= 1'b1;
            end else begin
                r_out.feat_score <= r_sc[0];
                r_out.feat_x     <= r_x[0];
                r_out.feat_y     <= r_y[0];
                r_out.none_found <= 1'b0;
            end
            r_out.is_last <= (r_count <= CNT_W'(1));
        end
    end

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.count_one  = (r_count == CNT_W'(1));
    assign o_out_data        = r_out;

endmodule

FILE: rtl/core/threshold_top_k_feature_select.sv
`timescale 1ns / 1ps
// Thresholded top-k feature selector. Takes one pixel request per cycle
// (corner score in unsigned Q8.24 with column and row); scores strictly above
// the threshold register go into a sorted compare-and-shift chain of up to
// min(max_count, 32) entries, best first, ties kept in arrival order. On the
// pixel flagged frame_end that pixel is inserted first, then the input stalls
// while the emit sequencer pops the chain head into the output register, one
// result per cycle when the consumer takes every cycle. A frame with no
// survivors gives a single result with none_found and is_last set and zero
// fields. The store needs no clearing pass; the fill count alone marks
// valid entries. Config writes are taken every cycle (o_cfg_ready is tied
// high), index 0 is score_threshold, index 1 is max_count, other indexes are
// ignored.
// depends on tkfs_pkg, tkfs_ctrl, tkfs_datapath
module threshold_top_k_feature_select import tkfs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    // feature result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  t_cfg_idx    i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // config writes must land only while idle (unenforced), no back-pressure
    assign o_cfg_ready = 1'b1;

    // sequencer: accept pixels, then unload the store after a frame end
    tkfs_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_frame_end (i_in_data.frame_end),
        .o_in_ready     (o_in_ready),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_stat         (w_stat),
        .o_cmd          (w_cmd)
    );

    // sorted store, config registers and output register
    tkfs_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: rtl/core/tkfs_checker.sv
`timescale 1ns / 1ps
// port-level checker for the top-k feature selector, bound to the top level
// depends on tkfs_pkg and assert_macros.svh
`include "assert_macros.svh"

module tkfs_checker import tkfs_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input t_in_item  i_in_data,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    // a waiting result holds
    `TKFS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))

    // empty result is alone and carries zero fields
    `TKFS_ASSERT_NOW(a_empty_form, i_clk, i_rst_n, i_out_valid && i_out_data.none_found, i_out_data.is_last && (i_out_data.feat_score == '0) && (i_out_data.feat_x == '0) && (i_out_data.feat_y == '0))

    // while a frame is still being unloaded no pixel is taken
    `TKFS_ASSERT_NOW(a_emit_stall, i_clk, i_rst_n, i_out_valid && !i_out_data.is_last, !i_in_ready)

    // a frame end request starts the unload
    `TKFS_ASSERT_NEXT(a_fend_stall, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_data.frame_end, !i_in_ready)

endmodule

bind threshold_top_k_feature_select tkfs_checker u_tkfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

FILE: verif/threshold_top_k_feature_select_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for threshold_top_k_feature_select: random pixel streams,
// a ranking scoreboard class and randomly stalling request/result sides
// depends on tkfs_pkg and the rtl of threshold_top_k_feature_select
module threshold_top_k_feature_select_tb;
    import tkfs_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int MAX_GAP        = 10;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 6;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PIXEL_TARGET   = 140;
    localparam int LONG_FRAME     = 36;

    // ranks accepted pixels the way the block should and holds the features
    // that each frame end is due to emit, oldest first
    class feature_scoreboard;
        logic [SCORE_BITS-1:0] threshold;
        logic [MAXC_BITS-1:0]  max_count;
        logic [SCORE_BITS-1:0] ranked_score [MAX_FEATURES];
        logic [COORD_BITS-1:0] ranked_x     [MAX_FEATURES];
        logic [COORD_BITS-1:0] ranked_y     [MAX_FEATURES];
        int unsigned           ranked_count;
        t_out_item             pending_features [$];
        int unsigned           pixels_seen;
        int unsigned           frames_seen;
        int unsigned           empty_frames;
        int unsigned           features_checked;
        int unsigned           mismatches;

        function new();
            threshold        = THRESHOLD_RESET;
            max_count        = MAX_COUNT_RESET;
            ranked_count     = 0;
            pixels_seen      = 0;
            frames_seen      = 0;
            empty_frames     = 0;
            features_checked = 0;
            mismatches       = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [31:0] value);
            case (idx)
                CFG_THRESHOLD: threshold = value;
                CFG_MAX_COUNT: max_count = value[MAXC_BITS-1:0];
                default: ;
            endcase
        endfunction

        // append one due feature at the tail of the queue
        function void queue_feature(t_out_item feat);
            pending_features = {pending_features, feat};
        endfunction

        function void take_pixel(t_in_item px);
            int unsigned cap;
            int unsigned pos;
            int unsigned tail;
            int unsigned i;
            t_out_item   feat;
            pixels_seen++;
            cap = (max_count < MAX_FEATURES) ? max_count : MAX_FEATURES;
            // a lowered cap trims the weakest entries first
            if (ranked_count > cap)
                ranked_count = cap;
            if (px.score > threshold && cap > 0) begin
                // new entry lands behind every equal or better score
                pos = 0;
                while (pos < ranked_count && ranked_score[pos] >= px.score)
                    pos++;
                if (pos < cap) begin
                    tail = (ranked_count < cap) ? ranked_count : cap - 1;
                    for (i = tail; i > pos; i--) begin
                        ranked_score[i] = ranked_score[i-1];
                        ranked_x[i]     = ranked_x[i-1];
                        ranked_y[i]     = ranked_y[i-1];
                    end
                    ranked_score[pos] = px.score;
                    ranked_x[pos]     = px.pix_x;
                    ranked_y[pos]     = px.pix_y;
                    if (ranked_count < cap)
                        ranked_count++;
                end
            end
            if (!px.frame_end)
                return;
            frames_seen++;
            if (ranked_count == 0) begin
                feat            = '0;
                feat.is_last    = 1'b1;
                feat.none_found = 1'b1;
                queue_feature(feat);
                empty_frames++;
            end else begin
                for (i = 0; i < ranked_count; i++) begin
                    feat            = '0;
                    feat.feat_score = ranked_score[i];
                    feat.feat_x     = ranked_x[i];
                    feat.feat_y     = ranked_y[i];
                    feat.is_last    = (i + 1 == ranked_count);
                    queue_feature(feat);
                end
            end
            ranked_count = 0;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 40)
                $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_feature(t_out_item got);
            t_out_item want;
            if (pending_features.size() == 0) begin
                report_mismatch($sformatf("unexpected result score %h x %0d y %0d",
                                          got.feat_score, got.feat_x, got.feat_y));
                return;
            end
            want = pending_features.pop_front();
            if (got.feat_score !== want.feat_score)
                report_mismatch($sformatf("result %0d score %h, want %h",
                                          features_checked, got.feat_score, want.feat_score));
            if (got.feat_x !== want.feat_x)
                report_mismatch($sformatf("result %0d x %0d, want %0d",
                                          features_checked, got.feat_x, want.feat_x));
            if (got.feat_y !== want.feat_y)
                report_mismatch($sformatf("result %0d y %0d, want %0d",
                                          features_checked, got.feat_y, want.feat_y));
            if (got.is_last !== want.is_last)
                report_mismatch($sformatf("result %0d is_last %b, want %b",
                                          features_checked, got.is_last, want.is_last));
            if (got.none_found !== want.none_found)
                report_mismatch($sformatf("result %0d none_found %b, want %b",
                                          features_checked, got.none_found, want.none_found));
            features_checked++;
        endtask
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index = CFG_THRESHOLD;
    logic [31:0] i_cfg_data  = '0;

    feature_scoreboard sb;
    bit                no_gaps      = 1'b0;  // both sides run without idling
    bit                hold_request = 1'b0;  // asks the result side for a long stall
    logic [31:0]       tie_pool [3];         // repeated scores to exercise tie order
    int unsigned       cfg_writes   = 0;
    int unsigned       quiet_cycles = 0;

    threshold_top_k_feature_select dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // drive one pixel request after a random gap and wait for it to be taken;
    // valid stays up on return so back-to-back requests need no dip
    task automatic push_pixel(logic [31:0] s, logic [11:0] x, logic [11:0] y, logic fend);
        t_in_item    px;
        int unsigned gap;
        px.score     = s;
        px.pix_x     = x;
        px.pix_y     = y;
        px.frame_end = fend;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data  = px;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.take_pixel(px);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, value);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // stop offering pixels, let every due feature come out, then give the
    // emit sequencer SETTLE_CYCLES to go idle before any register write
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending_features.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly values right at the threshold, ties and the extremes
    function automatic logic [31:0] pick_score();
        logic [31:0] thr;
        thr = sb.threshold;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return thr;
            3: return thr + 32'd1;
            4: return thr - 32'd1;
            5, 6: return tie_pool[$urandom_range(0, 2)];
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_threshold();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return THRESHOLD_RESET;
            3: return $urandom_range(0, 32'h0100_0000);
            default: return $urandom;
        endcase
    endfunction

    // cap values include zero, the store size, above it, and junk upper bits
    function automatic logic [31:0] pick_cap();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return MAX_FEATURES;
            2: return ($urandom & ~32'h3F) | 32'd63;
            3: return $urandom;
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    task automatic run_random_phase(int unsigned phase_no);
        int unsigned frames;
        int unsigned len;
        int unsigned f;
        int unsigned i;
        logic [11:0] x;
        logic [11:0] y;
        logic        open_end;
        no_gaps = ($urandom_range(0, 3) == 0);
        if (phase_no == 0) begin
            // one long frame that overfills the store with the cap above its size
            write_cfg(CFG_THRESHOLD, '0);
            write_cfg(CFG_MAX_COUNT, ($urandom & ~32'h3F) | 32'd63);
        end else begin
            if ($urandom_range(0, 2) != 0)
                write_cfg(CFG_THRESHOLD, pick_threshold());
            if ($urandom_range(0, 2) != 0)
                write_cfg(CFG_MAX_COUNT, pick_cap());
        end
        for (i = 0; i < 3; i++)
            tie_pool[i] = (sb.threshold > 32'hFFFF_0000) ? '1
                        : sb.threshold + $urandom_range(1, 65535);
        // the result side stalls long while frames keep coming in
        if (phase_no == 2)
            hold_request = 1'b1;
        frames = (phase_no == 0) ? 1 : (phase_no == 2) ? 4 : $urandom_range(1, 4);
        for (f = 0; f < frames; f++) begin
            if (phase_no == 0)
                len = LONG_FRAME;
            else if (phase_no == 2)
                len = $urandom_range(2, 5);
            else
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 10);
            // sometimes the phase ends mid-frame so the next writes land on a partial store
            open_end = (f == frames - 1) && (phase_no > 2) && ($urandom_range(0, 5) == 0);
            x = 12'($urandom_range(0, 4095));
            y = 12'($urandom_range(0, 4095));
            for (i = 0; i < len; i++) begin
                if ($urandom_range(0, 7) == 0) begin
                    x = 12'($urandom_range(0, 4095));
                    y = 12'($urandom_range(0, 4095));
                end
                push_pixel(pick_score(), x, y, (i == len - 1) && !open_end);
                {y, x} = {y, x} + 24'd1;
            end
        end
        wait_drained();
    endtask

    // result side: random stall per result, plus the long hold when asked
    initial begin : result_sink
        int unsigned stall;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end
            stall = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_feature(o_out_data);
        end
    end

    // watchdog: any handshake counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no handshake for %0d cycles, %0d results still due",
                     quiet_cycles, sb.pending_features.size());
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned phase_no;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: a score equal to the threshold is rejected, so this
        // frame has no survivors and gives the empty result
        push_pixel('0, 12'd0, 12'd0, 1'b0);
        push_pixel(THRESHOLD_RESET, 12'd4095, 12'd0, 1'b1);
        // just above threshold, the maximum score, a three-way tie in raster
        // order, and the frame-end pixel ranked before emission
        push_pixel(THRESHOLD_RESET + 32'd1, 12'd1, 12'd0, 1'b0);
        push_pixel('1, 12'd4095, 12'd4095, 1'b0);
        push_pixel(32'h0100_0000, 12'd2, 12'd0, 1'b0);
        push_pixel(32'h0100_0000, 12'd3, 12'd0, 1'b0);
        push_pixel(32'h0100_0000, 12'd0, 12'd4095, 1'b1);
        wait_drained();

        // cap of zero keeps nothing
        write_cfg(CFG_MAX_COUNT, '0);
        push_pixel('1, 12'd5, 12'd5, 1'b1);
        wait_drained();

        // cap of three with zero threshold: weakest entries fall off the end
        write_cfg(CFG_THRESHOLD, '0);
        write_cfg(CFG_MAX_COUNT, 32'd3);
        push_pixel(32'd1, 12'd10, 12'd1, 1'b0);
        push_pixel(32'd50, 12'd11, 12'd1, 1'b0);
        push_pixel(32'd7, 12'd12, 12'd1, 1'b0);
        push_pixel(32'd50, 12'd13, 12'd1, 1'b0);
        push_pixel(32'd2, 12'd14, 12'd1, 1'b1);
        wait_drained();

        // partial frame, then the cap drops to two (upper bits are junk)
        write_cfg(CFG_MAX_COUNT, 32'd8);
        push_pixel(32'd10, 12'd20, 12'd2, 1'b0);
        push_pixel(32'd20, 12'd21, 12'd2, 1'b0);
        push_pixel(32'd30, 12'd22, 12'd2, 1'b0);
        push_pixel(32'd40, 12'd23, 12'd2, 1'b0);
        wait_drained();
        write_cfg(CFG_MAX_COUNT, 32'hFFFF_FFC2);
        push_pixel(32'd5, 12'd24, 12'd2, 1'b1);
        wait_drained();

        // maximum threshold: even the maximum score fails
        write_cfg(CFG_THRESHOLD, '1);
        push_pixel('1, 12'd4095, 12'd4095, 1'b1);
        wait_drained();

        // the long result stall phase always runs
        phase_no = 0;
        while (sb.pixels_seen < PIXEL_TARGET || phase_no < 3) begin
            run_random_phase(phase_no);
            phase_no++;
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending_features.size() != 0)
            sb.report_mismatch($sformatf("%0d expected results never came",
                                         sb.pending_features.size()));
        $display("ranked %0d pixels over %0d frames, %0d of them empty; %0d results checked",
                 sb.pixels_seen, sb.frames_seen, sb.empty_frames, sb.features_checked);
        $display("%0d register writes across %0d random phases, one long result stall",
                 cfg_writes, phase_no);
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/tkfs_pkg.sv
rtl/core/tkfs_ctrl.sv
rtl/core/tkfs_datapath.sv
rtl/core/threshold_top_k_feature_select.sv
rtl/core/tkfs_checker.sv
verif/threshold_top_k_feature_select_tb.sv
